FILE: rtl/core/ilp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilp_pkg
// shared types, codes and constants of the integer literal parser
// ---------------------------------------------------------------------------
package ilp_pkg;

  // output value width and default accumulator width
  localparam int unsigned NUMBER_WIDTH       = 64;
  localparam int unsigned VALUE_BITS_DEFAULT = 64;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW = 3'd1;
  localparam logic [2:0] ERR_OCTAL    = 3'd2;
  localparam logic [2:0] ERR_NO_HEX   = 3'd3;
  localparam logic [2:0] ERR_NO_BIN   = 3'd4;
  localparam logic [2:0] ERR_NAN      = 3'd5;

  // radix codes
  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_OCT = 2'd2;
  localparam logic [1:0] RX_BIN = 2'd3;

  // one input byte
  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } item_t;

  // one parse result
  typedef struct packed {
    logic [NUMBER_WIDTH-1:0] number_value;
    logic [2:0]              error_code;
    logic [1:0]              radix_used;
    logic [7:0]              stop_byte;
    logic                    ended_by_text_end;
  } result_t;

endpackage : ilp_pkg
`default_nettype wire

FILE: rtl/core/ilp_in_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilp_in_stage
// input register: holds one byte until the parse stage takes it
// ---------------------------------------------------------------------------
module ilp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ilp_pkg::item_t in_item,
  input  wire logic          take,
  output logic               held_valid,
  output ilp_pkg::item_t     held_item
);
  import ilp_pkg::*;

  // free when empty or emptied in this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule : ilp_in_stage
`default_nettype wire

FILE: rtl/core/ilp_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilp_core
// token state and per-byte parse step
// ---------------------------------------------------------------------------
module ilp_core #(
  parameter int unsigned VALUE_BITS = ilp_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire ilp_pkg::item_t item,
  output logic                res_flag,
  output ilp_pkg::result_t    res
);
  import ilp_pkg::*;

  localparam int unsigned VB = VALUE_BITS;

  // token phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_MINUS = 2'd1;
  localparam logic [1:0] PH_ZERO  = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_B_LO  = 8'h62;

  // 16 means not a hex digit
  function automatic logic [4:0] digit_value(input logic [7:0] b);
    logic [4:0] d;
    d = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) d = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) d = 5'(b - 8'h61 + 8'd10);
    else if (b >= 8'h41 && b <= 8'h46) d = 5'(b - 8'h41 + 8'd10);
    return d;
  endfunction

  logic [1:0]    phase, phase_next;
  logic [1:0]    radix_sel, radix_sel_next;
  logic [VB-1:0] acc, acc_next;
  logic          minus_seen, minus_seen_next;
  logic [2:0]    first_error, first_error_next;
  logic          skipping, skipping_next;
  logic          any_digit, any_digit_next;

  logic [7:0]    b;
  logic [4:0]    dv;
  logic [VB-1:0] dv_ext;
  logic          is_space;
  logic [4:0]    base_lim;
  logic [4:0]    skip_lim;
  logic [VB+3:0] acc_wide;
  logic [VB+3:0] prod;
  logic [VB+3:0] sum;
  logic          ovf;
  logic          do_end;
  logic          nan;
  logic [7:0]    end_stop;
  logic          end_text;
  logic [2:0]    err_final;
  logic [VB-1:0] mag;
  logic signed [VB-1:0] sval;

  assign b        = item.text_byte;
  assign dv       = digit_value(b);
  assign dv_ext   = VB'(dv[3:0]);
  assign is_space = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
  assign acc_wide = {4'b0000, acc};

  // shift-add multiply by the radix and digit limits per radix; exact overflow test below
  always_comb begin
    case (radix_sel)
      RX_DEC:  begin prod = (acc_wide << 3) + (acc_wide << 1); base_lim = 5'd10; end
      RX_HEX:  begin prod = acc_wide << 4; base_lim = 5'd16; end
      RX_OCT:  begin prod = acc_wide << 3; base_lim = 5'd8; end
      default: begin prod = acc_wide << 1; base_lim = 5'd2; end
    endcase
    case (radix_sel)
      RX_HEX:  skip_lim = 5'd16;
      RX_BIN:  skip_lim = 5'd2;
      default: skip_lim = 5'd10;
    endcase
  end

  assign sum = prod + (VB + 4)'(dv[3:0]);
  assign ovf = |sum[VB+3:VB];

  always_comb begin
    phase_next       = phase;
    radix_sel_next   = radix_sel;
    acc_next         = acc;
    minus_seen_next  = minus_seen;
    first_error_next = first_error;
    skipping_next    = skipping;
    any_digit_next   = any_digit;
    do_end           = 1'b0;
    nan              = 1'b0;
    end_stop         = 8'd0;
    end_text         = 1'b0;

    case (phase)
      PH_START, PH_MINUS: begin
        if (phase == PH_START && b == CH_MINUS) begin
          minus_seen_next = 1'b1;
          phase_next      = PH_MINUS;
          if (item.is_last) begin
            nan = 1'b1; do_end = 1'b1; end_text = 1'b1;
          end
        end else if (phase == PH_MINUS && is_space) begin
          if (item.is_last) begin
            nan = 1'b1; do_end = 1'b1; end_text = 1'b1;
          end
        end else if (dv >= 5'd10) begin
          nan = 1'b1; do_end = 1'b1; end_stop = b;
        end else begin
          radix_sel_next = RX_DEC;
          acc_next       = dv_ext;
          any_digit_next = 1'b1;
          phase_next     = (dv == 5'd0) ? PH_ZERO : PH_BODY;
          if (item.is_last) begin
            do_end = 1'b1; end_text = 1'b1;
          end
        end
      end
      PH_ZERO: begin
        if (b == CH_X_LO || b == CH_X_UP || b == CH_B_LO || dv < 5'd10) begin
          if (b == CH_X_LO || b == CH_X_UP) begin
            radix_sel_next = RX_HEX;
            any_digit_next = 1'b0;
          end else if (b == CH_B_LO) begin
            radix_sel_next = RX_BIN;
            any_digit_next = 1'b0;
          end else if (dv < 5'd8) begin
            radix_sel_next = RX_OCT;
            acc_next       = dv_ext;
          end else begin
            radix_sel_next = RX_DEC;
            acc_next       = dv_ext;
          end
          phase_next = PH_BODY;
          if (item.is_last) begin
            do_end = 1'b1; end_text = 1'b1;
          end
        end else begin
          do_end = 1'b1; end_stop = b;
        end
      end
      default: begin
        if (skipping) begin
          if (dv >= skip_lim) begin
            do_end = 1'b1; end_stop = b;
          end
        end else if (radix_sel == RX_OCT && (dv == 5'd8 || dv == 5'd9)) begin
          if (first_error == ERR_NONE) first_error_next = ERR_OCTAL;
        end else if (dv < base_lim) begin
          any_digit_next = 1'b1;
          if (ovf) begin
            if (first_error == ERR_NONE) first_error_next = ERR_OVERFLOW;
            skipping_next = 1'b1;
          end else begin
            acc_next = sum[VB-1:0];
          end
        end else begin
          do_end = 1'b1; end_stop = b;
        end
        // a consumed last byte closes the literal
        if (!do_end && item.is_last) begin
          do_end = 1'b1; end_text = 1'b1;
        end
      end
    endcase

    // not a number: zero value, decimal
    if (nan) begin
      acc_next       = '0;
      radix_sel_next = RX_DEC;
      any_digit_next = 1'b1;
      if (first_error_next == ERR_NONE) first_error_next = ERR_NAN;
    end
  end

  // result fields from the closing state
  always_comb begin
    err_final = first_error_next;
    if (err_final == ERR_NONE && !any_digit_next) begin
      if (radix_sel_next == RX_HEX) err_final = ERR_NO_HEX;
      else if (radix_sel_next == RX_BIN) err_final = ERR_NO_BIN;
    end
    mag  = minus_seen_next ? (VB'(0) - acc_next) : acc_next;
    sval = mag;
    res.number_value      = NUMBER_WIDTH'(sval);
    res.error_code        = err_final;
    res.radix_used        = radix_sel_next;
    res.stop_byte         = end_stop;
    res.ended_by_text_end = end_text;
  end

  assign res_flag = do_end;

  always_ff @(posedge clk) begin
    if (rst || (take && do_end)) begin
      phase       <= PH_START;
      radix_sel   <= RX_DEC;
      acc         <= '0;
      minus_seen  <= 1'b0;
      first_error <= ERR_NONE;
      skipping    <= 1'b0;
      any_digit   <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      radix_sel   <= radix_sel_next;
      acc         <= acc_next;
      minus_seen  <= minus_seen_next;
      first_error <= first_error_next;
      skipping    <= skipping_next;
      any_digit   <= any_digit_next;
    end
  end

endmodule : ilp_core
`default_nettype wire

FILE: rtl/core/ilp_out_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilp_out_stage
// result register toward the receiver
// ---------------------------------------------------------------------------
module ilp_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic             res_flag,
  input  wire ilp_pkg::result_t res_in,
  output logic                  slot_free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ilp_pkg::result_t      res_out
);
  import ilp_pkg::*;

  logic load;

  assign slot_free = !out_valid || out_ready;
  assign load      = take && res_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule : ilp_out_stage
`default_nettype wire

FILE: rtl/core/integer_literal_parser_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// integer_literal_parser_top
// streaming integer literal parser, one text byte per transfer
// ---------------------------------------------------------------------------
// input channel: in_valid/in_ready with text_byte and is_last; one transfer
//   per byte. output channel: out_valid/out_ready with one result per
//   literal (value, error, radix, stop byte, text-end flag).
// a byte is taken into an input register, then parsed against the token
//   state, and a result lands in the output register.
// the result of a literal is registered in the result register once its
//   last byte has left the input register and been parsed.
// throughput: one byte per cycle while the receiver does not stall; the loop
//   that sets it is the token state update (accumulator times radix plus
//   digit, overflow test) in ilp_core.
// a stalled receiver holds the result register; while it is held the parse
//   stage takes no byte at all, the input register keeps its byte and
//   in_ready drops once the input register is full.
// reset (rst, synchronous): both registers empty, token state at start.
// ---------------------------------------------------------------------------
module integer_literal_parser_top #(
  parameter int unsigned VALUE_BITS = ilp_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       text_byte,
  input  wire logic                             is_last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [ilp_pkg::NUMBER_WIDTH-1:0] number_value,
  output logic [2:0]                            error_code,
  output logic [1:0]                            radix_used,
  output logic [7:0]                            stop_byte,
  output logic                                  ended_by_text_end
);
  import ilp_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    slot_free;
  logic    res_flag;
  result_t res_next;
  result_t res_q;

  assign in_item.text_byte = text_byte;
  assign in_item.is_last   = is_last;

  // a held byte is parsed when the result register can take a result
  assign take = held_valid && slot_free;

  ilp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ilp_core #(
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (held_item),
    .res_flag (res_flag),
    .res      (res_next)
  );

  ilp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_flag  (res_flag),
    .res_in    (res_next),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign number_value      = res_q.number_value;
  assign error_code        = res_q.error_code;
  assign radix_used        = res_q.radix_used;
  assign stop_byte         = res_q.stop_byte;
  assign ended_by_text_end = res_q.ended_by_text_end;

  // a held byte that is not parsed stays held
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && !take |=> held_valid)
    else $error("held byte dropped");

  // not-a-number results carry zero in decimal
  a_nan_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_NAN |-> number_value == '0 && radix_used == RX_DEC)
    else $error("not-a-number result with value");

  // a literal closed by text end reports no stop byte
  a_text_end_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && ended_by_text_end |-> stop_byte == 8'd0)
    else $error("text end with stop byte");

endmodule : integer_literal_parser_top
`default_nettype wire

FILE: tb/integer_literal_parser_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_literal_parser_top_tb
// self-checking bench for the streaming integer literal parser
// ---------------------------------------------------------------------------
// text bytes are queued up front (a short directed list, then random
// literals, broken prefixes and junk bytes) and driven one transfer at a
// time. every accepted byte is run through a local token model that
// predicts the parse result; returned results are checked in order.
// both channels idle at random, with calm stretches in between.
// ---------------------------------------------------------------------------
module integer_literal_parser_top_tb;
  import ilp_pkg::*;

  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [63:0] VALUE_MAX = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [63:0] SIGN_BIT  = (VALUE_MAX >> 1) + 64'd1;

  // where the token model stands within a literal
  typedef enum logic [1:0] {
    TOK_START,   // nothing seen yet
    TOK_SIGN,    // minus seen, blanks may follow
    TOK_ZERO,    // leading zero seen, prefix may follow
    TOK_DIGITS   // inside the digits of the body
  } tok_phase_t;

  // one queued byte; hold_first makes the sender wait until all results are in
  typedef struct {
    item_t item;
    bit    hold_first;
  } text_beat_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [7:0]                     text_byte = 8'h00;
  logic                           is_last   = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [NUMBER_WIDTH-1:0] number_value;
  logic [2:0]                     error_code;
  logic [1:0]                     radix_used;
  logic [7:0]                     stop_byte;
  logic                           ended_by_text_end;

  text_beat_t  text_q[$];
  result_t     predicted_literals[$];
  bit          hold_next = 1'b0;
  int unsigned mismatches = 0;
  int unsigned sent_count = 0;

  // token model state
  tok_phase_t  tok_phase     = TOK_START;
  logic [1:0]  tok_radix     = RX_DEC;
  logic [63:0] tok_acc       = '0;
  logic        tok_neg       = 1'b0;
  logic [2:0]  tok_err       = ERR_NONE;
  logic        tok_skip      = 1'b0;
  logic        tok_has_digit = 1'b0;

  // idle control
  int unsigned send_gap   = 0;
  int unsigned stall_left = 0;
  bit          send_calm  = 1'b0;
  bit          recv_calm  = 1'b0;
  int unsigned quiet_cycles = 0;

  integer_literal_parser_top #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .text_byte        (text_byte),
    .is_last          (is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .number_value     (number_value),
    .error_code       (error_code),
    .radix_used       (radix_used),
    .stop_byte        (stop_byte),
    .ended_by_text_end(ended_by_text_end)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // token model
  // ---------------------------------------------------------------------------

  // value of a digit character in any radix, 16 when it is no digit at all
  function automatic logic [4:0] digit_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return 5'(b - "0");
    if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
    if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
    return 5'd16;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [63:0] radix_base(input logic [1:0] rdx);
    case (rdx)
      RX_DEC:  return 64'd10;
      RX_HEX:  return 64'd16;
      RX_OCT:  return 64'd8;
      default: return 64'd2;
    endcase
  endfunction

  task automatic clear_token();
    tok_phase     = TOK_START;
    tok_radix     = RX_DEC;
    tok_acc       = '0;
    tok_neg       = 1'b0;
    tok_err       = ERR_NONE;
    tok_skip      = 1'b0;
    tok_has_digit = 1'b0;
  endtask

  // only the first error of a literal sticks
  task automatic note_error(input logic [2:0] code);
    if (tok_err == ERR_NONE) tok_err = code;
  endtask

  task automatic close_literal(input logic [7:0] stop, input logic ended);
    result_t     res;
    logic [63:0] v;
    if (tok_radix == RX_HEX && !tok_has_digit) note_error(ERR_NO_HEX);
    if (tok_radix == RX_BIN && !tok_has_digit) note_error(ERR_NO_BIN);
    v = tok_acc & VALUE_MAX;
    if (tok_neg) v = (64'd0 - v) & VALUE_MAX;
    if ((v & SIGN_BIT) != 0) v = v | ~VALUE_MAX;
    res.number_value      = v;
    res.error_code        = tok_err;
    res.radix_used        = tok_radix;
    res.stop_byte         = stop;
    res.ended_by_text_end = ended;
    predicted_literals.insert(predicted_literals.size(), res);
    clear_token();
  endtask

  task automatic reject_token(input logic [7:0] stop, input logic ended);
    tok_acc       = '0;
    tok_radix     = RX_DEC;
    tok_has_digit = 1'b1;
    note_error(ERR_NAN);
    close_literal(stop, ended);
  endtask

  // advance the token model by one accepted byte
  task automatic parse_text_byte(input logic [7:0] b, input logic last);
    logic [4:0]  dv;
    logic [63:0] base;
    logic [4:0]  lim;
    dv = digit_of(b);
    if (tok_phase == TOK_START || tok_phase == TOK_SIGN) begin
      if (tok_phase == TOK_START && b == "-") begin
        tok_neg   = 1'b1;
        tok_phase = TOK_SIGN;
        if (last) reject_token(8'h00, 1'b1);
      end else if (tok_phase == TOK_SIGN && is_blank(b)) begin
        if (last) reject_token(8'h00, 1'b1);
      end else if (dv >= 5'd10) begin
        reject_token(b, 1'b0);
      end else begin
        tok_radix     = RX_DEC;
        tok_acc       = 64'(dv);
        tok_has_digit = 1'b1;
        tok_phase     = (dv == 5'd0) ? TOK_ZERO : TOK_DIGITS;
        if (last) close_literal(8'h00, 1'b1);
      end
      return;
    end

    if (tok_phase == TOK_ZERO) begin
      if (b == "x" || b == "X") begin
        tok_radix     = RX_HEX;
        tok_has_digit = 1'b0;
      end else if (b == "b") begin
        tok_radix     = RX_BIN;
        tok_has_digit = 1'b0;
      end else if (dv < 5'd8) begin
        tok_radix = RX_OCT;
        tok_acc   = 64'(dv);
      end else if (dv < 5'd10) begin
        // zero then 8 or 9: decimal from the zero
        tok_radix = RX_DEC;
        tok_acc   = 64'(dv);
      end else begin
        close_literal(b, 1'b0);
        return;
      end
      tok_phase = TOK_DIGITS;
      if (last) close_literal(8'h00, 1'b1);
      return;
    end

    base = radix_base(tok_radix);
    if (tok_skip) begin
      // after overflow, swallow the rest of the digits (octal takes 0..9)
      lim = (tok_radix == RX_HEX) ? 5'd16 : (tok_radix == RX_BIN) ? 5'd2 : 5'd10;
      if (dv >= lim) begin
        close_literal(b, 1'b0);
        return;
      end
    end else if (tok_radix == RX_OCT && (dv == 5'd8 || dv == 5'd9)) begin
      note_error(ERR_OCTAL);
    end else if (64'(dv) < base) begin
      tok_has_digit = 1'b1;
      if (tok_acc > (VALUE_MAX - 64'(dv)) / base) begin
        note_error(ERR_OVERFLOW);
        tok_skip = 1'b1;
      end else begin
        tok_acc = tok_acc * base + 64'(dv);
      end
    end else begin
      close_literal(b, 1'b0);
      return;
    end
    if (last) close_literal(8'h00, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic last);
    text_beat_t beat;
    beat.item.text_byte = b;
    beat.item.is_last   = last;
    beat.hold_first     = hold_next;
    hold_next = 1'b0;
    text_q.insert(text_q.size(), beat);
  endtask

  // mostly short pauses, now and then a long one
  function automatic int unsigned pick_pause();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_blank();
    int unsigned n;
    n = $urandom_range(0, 5);
    return (n == 0) ? 8'h20 : 8'(8 + n);
  endfunction

  // a byte that is neither a hex digit nor x, X or b
  function automatic logic [7:0] pick_stop();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (digit_of(b) != 5'd16 || b == "x" || b == "X" || b == "b");
    return b;
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned n);
    if (n < 10) return 8'("0" + n);
    return 8'((($urandom_range(0, 1) != 0) ? "a" : "A") + n - 10);
  endfunction

  // a literal with random sign, radix, digits and ending, at times too long or with a stray octal 8 or 9
  task automatic gen_literal();
    logic [63:0] val;
    logic [63:0] base;
    logic [1:0]  rdx;
    logic [7:0]  digs[$];
    int unsigned shape;
    bit          end_on_last;
    case ($urandom_range(0, 3))
      0:       rdx = RX_DEC;
      1:       rdx = RX_HEX;
      2:       rdx = RX_OCT;
      default: rdx = RX_BIN;
    endcase
    base  = radix_base(rdx);
    val   = {$urandom, $urandom};
    shape = $urandom_range(0, 9);
    if (shape < 6) val = val >> $urandom_range(40, 63);
    else if (shape < 9) val = val >> $urandom_range(0, 39);
    else val = VALUE_MAX;
    do begin
      digs.push_front(digit_char(int'(val % base)));
      val = val / base;
    end while (val != 0);

    // around the top of the range: exact max, last digit changed, or too long
    if (shape == 9) begin
      case ($urandom_range(0, 2))
        0: ;
        1: digs[digs.size()-1] = digit_char($urandom_range(0, int'(base) - 1));
        default: repeat ($urandom_range(1, 3))
                   digs.insert(digs.size(),
                               digit_char($urandom_range(0, int'(base) - 1)));
      endcase
    end else if (shape >= 6 && $urandom_range(0, 9) == 0) begin
      digs.insert(digs.size(), digit_char($urandom_range(0, int'(base) - 1)));
    end
    // stray 8 or 9 among octal digits
    if (rdx == RX_OCT && $urandom_range(0, 7) == 0)
      digs.insert($urandom_range(0, digs.size()), ($urandom_range(0, 1) != 0) ? "8" : "9");

    if ($urandom_range(0, 9) < 3) begin
      push_byte("-", 1'b0);
      repeat ($urandom_range(0, 2)) push_byte(pick_blank(), 1'b0);
    end
    case (rdx)
      RX_HEX: begin
        push_byte("0", 1'b0);
        push_byte(($urandom_range(0, 1) != 0) ? "x" : "X", 1'b0);
      end
      RX_BIN: begin
        push_byte("0", 1'b0);
        push_byte("b", 1'b0);
      end
      RX_OCT: begin
        push_byte("0", 1'b0);
      end
      default: begin
        // zero then 8 or 9 is read as decimal
        if ($urandom_range(0, 9) == 0) begin
          push_byte("0", 1'b0);
          digs[0] = ($urandom_range(0, 1) != 0) ? "8" : "9";
        end
      end
    endcase
    end_on_last = ($urandom_range(0, 9) < 4);
    foreach (digs[i]) push_byte(digs[i], end_on_last && i == digs.size() - 1);
    if (!end_on_last) push_byte(pick_stop(), $urandom_range(0, 4) == 0);
  endtask

  // prefixes with nothing behind them, lone signs, bytes that start nothing
  task automatic gen_broken();
    int unsigned n;
    case ($urandom_range(0, 4))
      0, 1: begin
        push_byte("0", 1'b0);
        if ($urandom_range(0, 1) != 0) begin
          push_byte(($urandom_range(0, 2) == 0) ? "X" : ($urandom_range(0, 1) ? "x" : "b"), 1'b1);
        end else begin
          push_byte(($urandom_range(0, 1) != 0) ? "x" : "b", 1'b0);
          push_byte(pick_stop(), $urandom_range(0, 3) == 0);
        end
      end
      2: begin
        n = $urandom_range(0, 2);
        push_byte("-", n == 0);
        for (int k = 0; k < n; k++) push_byte(pick_blank(), k == n - 1);
      end
      3: begin
        push_byte("-", 1'b0);
        push_byte(pick_stop(), $urandom_range(0, 3) == 0);
      end
      default: begin
        push_byte(pick_stop(), $urandom_range(0, 3) == 0);
      end
    endcase
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 3))
      push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued bytes, predicts on every input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_text
    text_beat_t beat;
    if (rst) begin
      in_valid  <= 1'b0;
      text_byte <= 8'h00;
      is_last   <= 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid && in_ready) begin
        parse_text_byte(text_byte, is_last);
        sent_count++;
        if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      end
      // a byte still waiting for its transfer stays put
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() != 0 &&
                     !(text_q[0].hold_first && predicted_literals.size() != 0)) begin
          beat = text_q.pop_front();
          in_valid  <= 1'b1;
          text_byte <= beat.item.text_byte;
          is_last   <= beat.item.is_last;
          if (!send_calm && $urandom_range(0, 2) == 0) send_gap = pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each output transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    result_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_literals.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %0d error %0d stop %0h",
                   $time, number_value, error_code, stop_byte);
          mismatches++;
        end else begin
          want = predicted_literals.pop_front();
          if (number_value !== want.number_value) begin
            $display("%0t: number_value expected %0d got %0d",
                     $time, $signed(want.number_value), number_value);
            mismatches++;
          end
          if (error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d got %0d", $time, want.error_code, error_code);
            mismatches++;
          end
          if (radix_used !== want.radix_used) begin
            $display("%0t: radix_used expected %0d got %0d", $time, want.radix_used, radix_used);
            mismatches++;
          end
          if (stop_byte !== want.stop_byte) begin
            $display("%0t: stop_byte expected %0h got %0h", $time, want.stop_byte, stop_byte);
            mismatches++;
          end
          if (ended_by_text_end !== want.ended_by_text_end) begin
            $display("%0t: ended_by_text_end expected %0b got %0b",
                     $time, want.ended_by_text_end, ended_by_text_end);
            mismatches++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      end
      // receiver back-pressure
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!recv_calm && $urandom_range(0, 3) == 0) stall_left = pick_pause();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer means the block is stuck
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int unsigned stop_at;
    int unsigned next_hold_at;
    int unsigned pick;
    int unsigned total_bytes;

    // single digit closed by end of text
    push_byte("9", 1'b1);
    // minus and blanks, then the text runs out: not a number
    push_byte("-", 1'b0);
    push_byte(" ", 1'b0);
    push_byte(8'h0d, 1'b1);
    // top byte value starts nothing
    push_byte(8'hff, 1'b0);
    // hex prefix with no digits
    push_byte("0", 1'b0);
    push_byte("x", 1'b0);
    push_byte("z", 1'b0);
    // binary prefix with no digits, ended by text end
    push_byte("0", 1'b0);
    push_byte("b", 1'b1);
    // octal with a 9 in it
    push_byte("0", 1'b0);
    push_byte("7", 1'b0);
    push_byte("9", 1'b0);
    push_byte(";", 1'b0);
    // zero then 9 goes decimal
    push_byte("0", 1'b0);
    push_byte("9", 1'b0);
    push_byte(":", 1'b0);
    // negative with a tab after the sign, stop byte carries is_last
    push_byte("-", 1'b0);
    push_byte(8'h09, 1'b0);
    push_byte("5", 1'b0);
    push_byte(",", 1'b1);
    // upper-case hex prefix, mixed-case digits
    push_byte("0", 1'b0);
    push_byte("X", 1'b0);
    push_byte("A", 1'b0);
    push_byte("f", 1'b1);
    // binary digit
    push_byte("0", 1'b0);
    push_byte("b", 1'b0);
    push_byte("1", 1'b1);

    stop_at      = text_q.size() + RANDOM_BYTES;
    next_hold_at = text_q.size() + 150;
    while (text_q.size() < stop_at) begin
      // every so often the sender drains all results before going on
      if (text_q.size() >= next_hold_at) begin
        hold_next    = 1'b1;
        next_hold_at = next_hold_at + 200;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) gen_literal();
      else if (pick < 85) gen_broken();
      else gen_noise();
    end
    // close whatever token is still open
    push_byte(8'h0a, 1'b1);
    total_bytes = text_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // every byte transferred and predicted, then every result returned
    while (sent_count != total_bytes) @(posedge clk);
    while (predicted_literals.size() != 0) @(posedge clk);
    // catch any stray result after the last one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ilp_pkg.sv
rtl/core/ilp_in_stage.sv
rtl/core/ilp_core.sv
rtl/core/ilp_out_stage.sv
rtl/core/integer_literal_parser_top.sv
tb/integer_literal_parser_top_tb.sv
